// ===== hw/rtl/madg_pkg.sv =====
package madg_pkg;

    // internal widths
    localparam int VW = 50;   // vector element entering the normalizer
    localparam int QW = 48;   // quaternion rate
    localparam int SW = 40;   // gradient
    localparam int WW = 49;   // integrated quaternion before renormalizing
    localparam int AW = 82;   // accumulator
    localparam int PW = 66;   // multiplier product

    localparam logic [0:0] CFG_BETA   = 1'b0;
    localparam logic [0:0] CFG_PERIOD = 1'b1;

    // microprogram segment bounds
    localparam logic [5:0] PC_G_END = 6'd11;
    localparam logic [5:0] PC_S_BEG = 6'd12;
    localparam logic [5:0] PC_S_END = 6'd39;
    localparam logic [5:0] PC_B_BEG = 6'd40;
    localparam logic [5:0] PC_P_BEG = 6'd44;
    localparam logic [5:0] PC_P_END = 6'd51;

    typedef logic signed [VW-1:0] t_nv;

    typedef enum logic [3:0] {
        SG_Q, SG_G, SG_N, SG_QQ, SG_ONE, SG_BETA, SG_SN, SG_QDH, SG_QDL, SG_PER
    } t_sgrp;

    typedef enum logic [2:0] {
        DG_NONE, DG_QD, DG_QQ, DG_S, DG_QB, DG_W
    } t_dgrp;

    typedef enum logic [1:0] {SH_16, SH_30, SH_L24, SH_0} t_shf;

    typedef enum logic [1:0] {NS_ACC, NS_S, NS_W} t_nsel;

    typedef struct packed {
        t_sgrp      grp;
        logic [1:0] idx;
    } t_src;

    typedef struct packed {
        t_src       a;
        t_src       b;
        t_shf       shf;
        logic       neg;
        logic [1:0] csh;    // term is scaled by 2**csh
        logic       first;
        t_dgrp      dgrp;
        logic [1:0] didx;
    } t_uop;

    typedef struct packed {
        logic  cap_in;
        logic  mul_en;
        logic  acc_en;
        t_uop  uop;
        logic  norm_start;
        t_nsel nsel;
        logic  ld_n;
        logic  ld_sn;
        logic  ld_q;
        logic  flag_set;
        logic  ld_out;
    } t_cmd;

    typedef struct packed {
        logic accel_zero;
        logic norm_done;
        logic norm_zero;
    } t_sts;

    function automatic t_uop mk(input t_sgrp ag, input logic [1:0] ai,
                                input t_sgrp bg, input logic [1:0] bi,
                                input t_shf sh, input logic ng, input logic [1:0] cs,
                                input logic fs, input t_dgrp dg, input logic [1:0] di);
        t_uop u;
        u.a.grp = ag;  u.a.idx = ai;
        u.b.grp = bg;  u.b.idx = bi;
        u.shf = sh;    u.neg = ng;   u.csh = cs;
        u.first = fs;  u.dgrp = dg;  u.didx = di;
        return u;
    endfunction

    function automatic t_uop uop_rom(input logic [5:0] pc);
        t_uop u;
        case (pc)
            // quaternion rate from the gyro
            6'd0:  u = mk(SG_Q, 2'd1, SG_G, 2'd0, SH_16, 1'b1, 2'd0, 1'b1, DG_NONE, 2'd0);
            6'd1:  u = mk(SG_Q, 2'd2, SG_G, 2'd1, SH_16, 1'b1, 2'd0, 1'b0, DG_NONE, 2'd0);
            6'd2:  u = mk(SG_Q, 2'd3, SG_G, 2'd2, SH_16, 1'b1, 2'd0, 1'b0, DG_QD, 2'd0);
            6'd3:  u = mk(SG_Q, 2'd0, SG_G, 2'd0, SH_16, 1'b0, 2'd0, 1'b1, DG_NONE, 2'd0);
            6'd4:  u = mk(SG_Q, 2'd2, SG_G, 2'd2, SH_16, 1'b0, 2'd0, 1'b0, DG_NONE, 2'd0);
            6'd5:  u = mk(SG_Q, 2'd3, SG_G, 2'd1, SH_16, 1'b1, 2'd0, 1'b0, DG_QD, 2'd1);
            6'd6:  u = mk(SG_Q, 2'd0, SG_G, 2'd1, SH_16, 1'b0, 2'd0, 1'b1, DG_NONE, 2'd0);
            6'd7:  u = mk(SG_Q, 2'd1, SG_G, 2'd2, SH_16, 1'b1, 2'd0, 1'b0, DG_NONE, 2'd0);
            6'd8:  u = mk(SG_Q, 2'd3, SG_G, 2'd0, SH_16, 1'b0, 2'd0, 1'b0, DG_QD, 2'd2);
            6'd9:  u = mk(SG_Q, 2'd0, SG_G, 2'd2, SH_16, 1'b0, 2'd0, 1'b1, DG_NONE, 2'd0);
            6'd10: u = mk(SG_Q, 2'd1, SG_G, 2'd1, SH_16, 1'b0, 2'd0, 1'b0, DG_NONE, 2'd0);
            6'd11: u = mk(SG_Q, 2'd2, SG_G, 2'd0, SH_16, 1'b1, 2'd0, 1'b0, DG_QD, 2'd3);
            // squares of the quaternion
            6'd12: u = mk(SG_Q, 2'd0, SG_Q, 2'd0, SH_30, 1'b0, 2'd0, 1'b1, DG_QQ, 2'd0);
            6'd13: u = mk(SG_Q, 2'd1, SG_Q, 2'd1, SH_30, 1'b0, 2'd0, 1'b1, DG_QQ, 2'd1);
            6'd14: u = mk(SG_Q, 2'd2, SG_Q, 2'd2, SH_30, 1'b0, 2'd0, 1'b1, DG_QQ, 2'd2);
            6'd15: u = mk(SG_Q, 2'd3, SG_Q, 2'd3, SH_30, 1'b0, 2'd0, 1'b1, DG_QQ, 2'd3);
            // gradient, w component
            6'd16: u = mk(SG_Q, 2'd0, SG_QQ, 2'd2, SH_30, 1'b0, 2'd2, 1'b1, DG_NONE, 2'd0);
            6'd17: u = mk(SG_Q, 2'd2, SG_N, 2'd0, SH_30, 1'b0, 2'd1, 1'b0, DG_NONE, 2'd0);
            6'd18: u = mk(SG_Q, 2'd0, SG_QQ, 2'd1, SH_30, 1'b0, 2'd2, 1'b0, DG_NONE, 2'd0);
            6'd19: u = mk(SG_Q, 2'd1, SG_N, 2'd1, SH_30, 1'b1, 2'd1, 1'b0, DG_S, 2'd0);
            // gradient, x component
            6'd20: u = mk(SG_Q, 2'd1, SG_QQ, 2'd3, SH_30, 1'b0, 2'd2, 1'b1, DG_NONE, 2'd0);
            6'd21: u = mk(SG_Q, 2'd3, SG_N, 2'd0, SH_30, 1'b1, 2'd1, 1'b0, DG_NONE, 2'd0);
            6'd22: u = mk(SG_QQ, 2'd0, SG_Q, 2'd1, SH_30, 1'b0, 2'd2, 1'b0, DG_NONE, 2'd0);
            6'd23: u = mk(SG_Q, 2'd0, SG_N, 2'd1, SH_30, 1'b1, 2'd1, 1'b0, DG_NONE, 2'd0);
            6'd24: u = mk(SG_Q, 2'd1, SG_ONE, 2'd0, SH_30, 1'b1, 2'd2, 1'b0, DG_NONE, 2'd0);
            6'd25: u = mk(SG_Q, 2'd1, SG_QQ, 2'd1, SH_30, 1'b0, 2'd3, 1'b0, DG_NONE, 2'd0);
            6'd26: u = mk(SG_Q, 2'd1, SG_QQ, 2'd2, SH_30, 1'b0, 2'd3, 1'b0, DG_NONE, 2'd0);
            6'd27: u = mk(SG_Q, 2'd1, SG_N, 2'd2, SH_30, 1'b0, 2'd2, 1'b0, DG_S, 2'd1);
            // gradient, y component
            6'd28: u = mk(SG_QQ, 2'd0, SG_Q, 2'd2, SH_30, 1'b0, 2'd2, 1'b1, DG_NONE, 2'd0);
            6'd29: u = mk(SG_Q, 2'd0, SG_N, 2'd0, SH_30, 1'b0, 2'd1, 1'b0, DG_NONE, 2'd0);
            6'd30: u = mk(SG_Q, 2'd2, SG_QQ, 2'd3, SH_30, 1'b0, 2'd2, 1'b0, DG_NONE, 2'd0);
            6'd31: u = mk(SG_Q, 2'd3, SG_N, 2'd1, SH_30, 1'b1, 2'd1, 1'b0, DG_NONE, 2'd0);
            6'd32: u = mk(SG_Q, 2'd2, SG_ONE, 2'd0, SH_30, 1'b1, 2'd2, 1'b0, DG_NONE, 2'd0);
            6'd33: u = mk(SG_Q, 2'd2, SG_QQ, 2'd1, SH_30, 1'b0, 2'd3, 1'b0, DG_NONE, 2'd0);
            6'd34: u = mk(SG_Q, 2'd2, SG_QQ, 2'd2, SH_30, 1'b0, 2'd3, 1'b0, DG_NONE, 2'd0);
            6'd35: u = mk(SG_Q, 2'd2, SG_N, 2'd2, SH_30, 1'b0, 2'd2, 1'b0, DG_S, 2'd2);
            // gradient, z component
            6'd36: u = mk(SG_QQ, 2'd1, SG_Q, 2'd3, SH_30, 1'b0, 2'd2, 1'b1, DG_NONE, 2'd0);
            6'd37: u = mk(SG_Q, 2'd1, SG_N, 2'd0, SH_30, 1'b1, 2'd1, 1'b0, DG_NONE, 2'd0);
            6'd38: u = mk(SG_QQ, 2'd2, SG_Q, 2'd3, SH_30, 1'b0, 2'd2, 1'b0, DG_NONE, 2'd0);
            6'd39: u = mk(SG_Q, 2'd2, SG_N, 2'd1, SH_30, 1'b1, 2'd1, 1'b0, DG_S, 2'd3);
            // subtract beta times the unit gradient
            6'd40: u = mk(SG_BETA, 2'd0, SG_SN, 2'd0, SH_16, 1'b1, 2'd0, 1'b1, DG_QB, 2'd0);
            6'd41: u = mk(SG_BETA, 2'd0, SG_SN, 2'd1, SH_16, 1'b1, 2'd0, 1'b1, DG_QB, 2'd1);
            6'd42: u = mk(SG_BETA, 2'd0, SG_SN, 2'd2, SH_16, 1'b1, 2'd0, 1'b1, DG_QB, 2'd2);
            6'd43: u = mk(SG_BETA, 2'd0, SG_SN, 2'd3, SH_16, 1'b1, 2'd0, 1'b1, DG_QB, 2'd3);
            // integrate over the sample period, in two partial products
            6'd44: u = mk(SG_QDH, 2'd0, SG_PER, 2'd0, SH_L24, 1'b0, 2'd0, 1'b1, DG_NONE, 2'd0);
            6'd45: u = mk(SG_QDL, 2'd0, SG_PER, 2'd0, SH_0, 1'b0, 2'd0, 1'b0, DG_W, 2'd0);
            6'd46: u = mk(SG_QDH, 2'd1, SG_PER, 2'd0, SH_L24, 1'b0, 2'd0, 1'b1, DG_NONE, 2'd0);
            6'd47: u = mk(SG_QDL, 2'd1, SG_PER, 2'd0, SH_0, 1'b0, 2'd0, 1'b0, DG_W, 2'd1);
            6'd48: u = mk(SG_QDH, 2'd2, SG_PER, 2'd0, SH_L24, 1'b0, 2'd0, 1'b1, DG_NONE, 2'd0);
            6'd49: u = mk(SG_QDL, 2'd2, SG_PER, 2'd0, SH_0, 1'b0, 2'd0, 1'b0, DG_W, 2'd2);
            6'd50: u = mk(SG_QDH, 2'd3, SG_PER, 2'd0, SH_L24, 1'b0, 2'd0, 1'b1, DG_NONE, 2'd0);
            6'd51: u = mk(SG_QDL, 2'd3, SG_PER, 2'd0, SH_0, 1'b0, 2'd0, 1'b0, DG_W, 2'd3);
            default: u = mk(SG_ONE, 2'd0, SG_ONE, 2'd0, SH_0, 1'b0, 2'd0, 1'b1, DG_NONE, 2'd0);
        endcase
        return u;
    endfunction

endpackage

// ===== hw/rtl/madgwick_imu_orientation_update_unit.sv =====
// Madgwick IMU orientation update, one gradient-descent step per sample.
//
// Input stream (s_axis): one gyro + accelerometer sample per item. Output
// stream (m_axis): the renormalized orientation quaternion after that update,
// with tuser set when the accelerometer correction was applied.
// Configuration: i_cfg_we writes beta (index 0, Q0.16) or the sample period
// (index 1, Q0.32 seconds); write only while the unit is idle.
//
// Timing: one item at a time. A sample runs 52 multiply-accumulate steps on
// the shared 33x33 multiplier, plus three vector normalizations, each with a
// 32-step square root and four 31-step restoring divisions in madg_norm.
// A zero gradient drops the four beta steps. With a zero accelerometer vector
// the accelerometer and gradient normalizations and all gradient steps drop
// out. The next item is accepted as soon as the previous result sits in the
// output register; if the receiver stalls, the finished quaternion waits
// there and the following update holds at its last step until it is taken.
// Reset: orientation returns to identity, beta to 6554, period to 42949673.
module madgwick_imu_orientation_update_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // gyro_x, gyro_y, gyro_z (32 each), accel_x, accel_y, accel_z (16 each)
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // q_w, q_x, q_y, q_z (32 each)
    output logic [127:0] m_axis_tdata,
    // feedback_applied
    output logic [0:0]   m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata
);

    madg_pkg::t_cmd w_cmd;
    madg_pkg::t_sts w_sts;
    logic           w_flag;

    madg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    madg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_q_data    (m_axis_tdata),
        .o_flag      (w_flag)
    );

    assign m_axis_tuser = w_flag;

endmodule

// ===== hw/rtl/madg_norm.sv =====
module madg_norm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  madg_pkg::t_nv     i_vec [4],
    output logic              o_done,
    output logic              o_zero,
    output logic signed [31:0] o_unit [4]
);

    typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DIV} t_nst;

    localparam int VW = madg_pkg::VW;

    t_nst              r_st;
    logic [VW-1:0]     r_m [4];
    logic              r_neg [4];
    logic [61:0]       r_sq;
    logic [63:0]       r_sum, r_rem, r_root, r_bit;
    logic [4:0]        r_cnt;
    logic [1:0]        r_k;
    logic [31:0]       r_n;
    logic [32:0]       r_drem;
    logic [30:0]       r_quo;
    logic signed [31:0] r_unit [4];
    logic              r_done, r_zero;

    logic [VW-1:0] w_or;
    logic [63:0]   w_rb, n_root, n_rem;
    logic [32:0]   w_t, n_drem;
    logic          w_ge;
    logic [30:0]   n_quo;
    logic          w_allz;

    assign w_or   = r_m[0] | r_m[1] | r_m[2] | r_m[3];
    assign w_allz = (i_vec[0] == '0) && (i_vec[1] == '0) && (i_vec[2] == '0)
                    && (i_vec[3] == '0);

    always_comb begin
        w_rb = r_root + r_bit;
        if (r_rem >= w_rb) begin
            n_rem  = r_rem - w_rb;
            n_root = (r_root >> 1) + r_bit;
        end else begin
            n_rem  = r_rem;
            n_root = r_root >> 1;
        end
        // first step yields the integer bit, later steps shift in fraction bits
        w_t    = (r_cnt == 5'd0) ? r_drem : (r_drem << 1);
        w_ge   = w_t >= {1'b0, r_n};
        n_drem = w_ge ? (w_t - {1'b0, r_n}) : w_t;
        n_quo  = {r_quo[29:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= N_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                N_IDLE: begin
                    if (i_start) begin
                        if (w_allz) begin
                            r_done <= 1'b1;
                            r_zero <= 1'b1;
                        end else begin
                            r_zero <= 1'b0;
                            r_st   <= N_SHIFT;
                        end
                        for (int i = 0; i < 4; i++) begin
                            r_neg[i] <= i_vec[i] < 0;
                            r_m[i]   <= (i_vec[i] < 0) ? VW'(-i_vec[i]) : VW'(i_vec[i]);
                        end
                    end
                end
                N_SHIFT: begin
                    // bring the largest magnitude into [2^30, 2^31)
                    if (|w_or[VW-1:39]) begin
                        for (int i = 0; i < 4; i++) r_m[i] <= r_m[i] >> 8;
                    end else if (|w_or[VW-1:31]) begin
                        for (int i = 0; i < 4; i++) r_m[i] <= r_m[i] >> 1;
                    end else if (w_or[VW-1:22] == '0) begin
                        for (int i = 0; i < 4; i++) r_m[i] <= r_m[i] << 8;
                    end else if (!w_or[30]) begin
                        for (int i = 0; i < 4; i++) r_m[i] <= r_m[i] << 1;
                    end else begin
                        r_st  <= N_SQ;
                        r_cnt <= '0;
                        r_sum <= '0;
                    end
                end
                N_SQ: begin
                    r_sq <= r_m[r_cnt[1:0]][30:0] * r_m[r_cnt[1:0]][30:0];
                    if (r_cnt != 5'd0) r_sum <= r_sum + 64'(r_sq);
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd4) begin
                        r_rem  <= r_sum + 64'(r_sq);
                        r_root <= '0;
                        r_bit  <= 64'h4000_0000_0000_0000;
                        r_cnt  <= '0;
                        r_st   <= N_SQRT;
                    end
                end
                N_SQRT: begin
                    r_rem  <= n_rem;
                    r_root <= n_root;
                    r_bit  <= r_bit >> 2;
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_n    <= n_root[31:0];
                        r_k    <= '0;
                        r_cnt  <= '0;
                        r_drem <= {2'b00, r_m[0][30:0]};
                        r_quo  <= '0;
                        r_st   <= N_DIV;
                    end
                end
                N_DIV: begin
                    r_drem <= n_drem;
                    r_quo  <= n_quo;
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'd30) begin
                        r_unit[r_k] <= r_neg[r_k] ? -$signed({1'b0, n_quo})
                                                  : $signed({1'b0, n_quo});
                        r_cnt <= '0;
                        r_quo <= '0;
                        if (r_k == 2'd3) begin
                            r_done <= 1'b1;
                            r_st   <= N_IDLE;
                        end else begin
                            r_k    <= r_k + 2'd1;
                            r_drem <= {2'b00, r_m[r_k + 2'd1][30:0]};
                        end
                    end
                end
                default: r_st <= N_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_zero = r_zero;
    assign o_unit = r_unit;

endmodule

// ===== hw/rtl/madg_dp.sv =====
module madg_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  madg_pkg::t_cmd i_cmd,
    output madg_pkg::t_sts o_sts,
    input  logic [143:0]   i_in_data,
    input  logic           i_cfg_we,
    input  logic [0:0]     i_cfg_addr,
    input  logic [31:0]    i_cfg_wdata,
    output logic [127:0]   o_q_data,
    output logic           o_flag
);

    localparam int QW = madg_pkg::QW;
    localparam int SW = madg_pkg::SW;
    localparam int WW = madg_pkg::WW;
    localparam int AW = madg_pkg::AW;
    localparam int PW = madg_pkg::PW;
    localparam int VW = madg_pkg::VW;

    logic signed [31:0]   r_q  [4];
    logic signed [31:0]   r_g  [3];
    logic signed [15:0]   r_a  [3];
    logic [15:0]          r_beta;
    logic [31:0]          r_per;
    logic signed [QW-1:0] r_qd [4];
    logic signed [31:0]   r_n  [3];
    logic signed [31:0]   r_qq [4];
    logic signed [SW-1:0] r_s  [4];
    logic signed [31:0]   r_sn [4];
    logic signed [WW-1:0] r_w  [4];
    logic signed [AW-1:0] r_acc;
    logic signed [PW-1:0] r_prod;
    logic                 r_flag, r_oflag;
    logic [127:0]         r_out;

    madg_pkg::t_uop       w_u;
    logic signed [AW-1:0] w_pe, w_term, n_acc;
    madg_pkg::t_nv        w_vec [4];
    logic signed [31:0]   w_unit [4];
    logic                 w_ndone, w_nzero;

    function automatic logic signed [32:0] opnd(input madg_pkg::t_src s);
        logic signed [32:0] v;
        case (s.grp)
            madg_pkg::SG_Q:    v = 33'(r_q[s.idx]);
            madg_pkg::SG_G:    v = (s.idx == 2'd0) ? 33'(r_g[0]) :
                                   (s.idx == 2'd1) ? 33'(r_g[1]) : 33'(r_g[2]);
            madg_pkg::SG_N:    v = (s.idx == 2'd0) ? 33'(r_n[0]) :
                                   (s.idx == 2'd1) ? 33'(r_n[1]) : 33'(r_n[2]);
            madg_pkg::SG_QQ:   v = 33'(r_qq[s.idx]);
            madg_pkg::SG_ONE:  v = 33'sh0_4000_0000;
            madg_pkg::SG_BETA: v = $signed({17'd0, r_beta});
            madg_pkg::SG_SN:   v = 33'(r_sn[s.idx]);
            madg_pkg::SG_QDH:  v = 33'($signed(r_qd[s.idx][QW-1:24]));
            madg_pkg::SG_QDL:  v = $signed({9'd0, r_qd[s.idx][23:0]});
            madg_pkg::SG_PER:  v = $signed({1'b0, r_per});
            default:           v = '0;
        endcase
        return v;
    endfunction

    assign w_u = i_cmd.uop;

    always_comb begin
        case (w_u.shf)
            madg_pkg::SH_16:  w_pe = AW'(r_prod >>> 16);
            madg_pkg::SH_30:  w_pe = AW'(r_prod >>> 30);
            madg_pkg::SH_L24: w_pe = AW'(r_prod) <<< 24;
            default:          w_pe = AW'(r_prod);
        endcase
        w_term = w_pe <<< w_u.csh;
        if (w_u.neg) w_term = -w_term;
        n_acc = w_u.first ? w_term : (r_acc + w_term);
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            case (i_cmd.nsel)
                madg_pkg::NS_ACC: w_vec[i] = (i < 3) ? VW'(r_a[i % 3]) : '0;
                madg_pkg::NS_S:   w_vec[i] = VW'(r_s[i]);
                default:          w_vec[i] = VW'(r_w[i]);
            endcase
        end
    end

    madg_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.norm_start),
        .i_vec   (w_vec),
        .o_done  (w_ndone),
        .o_zero  (w_nzero),
        .o_unit  (w_unit)
    );

    // configuration and orientation state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta <= 16'd6554;
            r_per  <= 32'd42949673;
            r_q[0] <= 32'sh4000_0000;
            r_q[1] <= '0;
            r_q[2] <= '0;
            r_q[3] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    madg_pkg::CFG_BETA:   r_beta <= i_cfg_wdata[15:0];
                    madg_pkg::CFG_PERIOD: r_per  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.ld_q) begin
                if (w_nzero) begin
                    r_q[0] <= 32'sh4000_0000;
                    r_q[1] <= '0;
                    r_q[2] <= '0;
                    r_q[3] <= '0;
                end else begin
                    r_q <= w_unit;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_g[0] <= i_in_data[31:0];
            r_g[1] <= i_in_data[63:32];
            r_g[2] <= i_in_data[95:64];
            r_a[0] <= i_in_data[111:96];
            r_a[1] <= i_in_data[127:112];
            r_a[2] <= i_in_data[143:128];
            r_flag <= 1'b0;
        end
        if (i_cmd.flag_set) r_flag <= 1'b1;
        if (i_cmd.mul_en) r_prod <= opnd(w_u.a) * opnd(w_u.b);
        if (i_cmd.acc_en) begin
            r_acc <= n_acc;
            case (w_u.dgrp)
                madg_pkg::DG_QD: r_qd[w_u.didx] <= QW'(n_acc >>> 1);
                madg_pkg::DG_QQ: r_qq[w_u.didx] <= n_acc[31:0];
                madg_pkg::DG_S:  r_s[w_u.didx]  <= n_acc[SW-1:0];
                madg_pkg::DG_QB: r_qd[w_u.didx] <= r_qd[w_u.didx] + QW'(n_acc);
                madg_pkg::DG_W:  r_w[w_u.didx]  <= WW'(r_q[w_u.didx]) + WW'(n_acc >>> 32);
                default: ;
            endcase
        end
        if (i_cmd.ld_n) begin
            r_n[0] <= w_unit[0];
            r_n[1] <= w_unit[1];
            r_n[2] <= w_unit[2];
        end
        if (i_cmd.ld_sn) r_sn <= w_unit;
        if (i_cmd.ld_out) begin
            r_out   <= {r_q[3], r_q[2], r_q[1], r_q[0]};
            r_oflag <= r_flag;
        end
    end

    assign o_sts.accel_zero = (r_a[0] == '0) && (r_a[1] == '0) && (r_a[2] == '0);
    assign o_sts.norm_done  = w_ndone;
    assign o_sts.norm_zero  = w_nzero;
    assign o_q_data = r_out;
    assign o_flag   = r_oflag;

endmodule

// ===== hw/rtl/madg_ctrl.sv =====
module madg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  madg_pkg::t_sts i_sts,
    output madg_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {C_IDLE, C_MUL, C_ACC, C_NGO, C_NWAIT, C_FIN} t_cst;

    t_cst            r_st;
    logic [5:0]      r_pc;
    madg_pkg::t_nsel r_nsel;
    logic            r_ovalid;

    always_comb begin
        o_cmd            = '0;
        o_cmd.uop        = madg_pkg::uop_rom(r_pc);
        o_cmd.nsel       = r_nsel;
        o_cmd.cap_in     = (r_st == C_IDLE) && i_in_valid;
        o_cmd.mul_en     = (r_st == C_MUL);
        o_cmd.acc_en     = (r_st == C_ACC);
        o_cmd.norm_start = (r_st == C_NGO);
        if (r_st == C_NWAIT && i_sts.norm_done) begin
            case (r_nsel)
                madg_pkg::NS_ACC: o_cmd.ld_n = 1'b1;
                madg_pkg::NS_S: begin
                    o_cmd.ld_sn    = !i_sts.norm_zero;
                    o_cmd.flag_set = !i_sts.norm_zero;
                end
                default: o_cmd.ld_q = 1'b1;
            endcase
        end
        o_cmd.ld_out = (r_st == C_FIN) && (!r_ovalid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= C_IDLE;
            r_pc     <= '0;
            r_nsel   <= madg_pkg::NS_ACC;
            r_ovalid <= 1'b0;
        end else begin
            if (o_cmd.ld_out) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
            case (r_st)
                C_IDLE: begin
                    if (i_in_valid) begin
                        r_pc <= '0;
                        r_st <= C_MUL;
                    end
                end
                C_MUL: r_st <= C_ACC;
                C_ACC: begin
                    if (r_pc == madg_pkg::PC_G_END) begin
                        if (i_sts.accel_zero) begin
                            r_pc <= madg_pkg::PC_P_BEG;
                            r_st <= C_MUL;
                        end else begin
                            r_nsel <= madg_pkg::NS_ACC;
                            r_st   <= C_NGO;
                        end
                    end else if (r_pc == madg_pkg::PC_S_END) begin
                        r_nsel <= madg_pkg::NS_S;
                        r_st   <= C_NGO;
                    end else if (r_pc == madg_pkg::PC_P_END) begin
                        r_nsel <= madg_pkg::NS_W;
                        r_st   <= C_NGO;
                    end else begin
                        r_pc <= r_pc + 6'd1;
                        r_st <= C_MUL;
                    end
                end
                C_NGO: r_st <= C_NWAIT;
                C_NWAIT: begin
                    if (i_sts.norm_done) begin
                        case (r_nsel)
                            madg_pkg::NS_ACC: begin
                                r_pc <= madg_pkg::PC_S_BEG;
                                r_st <= C_MUL;
                            end
                            madg_pkg::NS_S: begin
                                // skip the correction on a zero gradient
                                r_pc <= i_sts.norm_zero ? madg_pkg::PC_P_BEG
                                                        : madg_pkg::PC_B_BEG;
                                r_st <= C_MUL;
                            end
                            default: r_st <= C_FIN;
                        endcase
                    end
                end
                C_FIN: begin
                    if (!r_ovalid || i_out_ready) r_st <= C_IDLE;
                end
                default: r_st <= C_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_st == C_IDLE);
    assign o_out_valid = r_ovalid;

endmodule

// ===== sim/madgwick_imu_orientation_update_unit_tb.sv =====
`timescale 1ns / 100ps

module madgwick_imu_orientation_update_unit_tb;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 700;
    localparam int LONG_HOLD = 3000;

    typedef struct {
        logic signed [31:0] qw;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] qz;
        logic               fb;
    } t_quat;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         i_cfg_we = 1'b0;
    logic [0:0]   i_cfg_addr = madg_pkg::CFG_BETA;
    logic [31:0]  i_cfg_wdata = '0;

    // model state
    logic signed [31:0] att_q [4];
    logic [15:0]        beta_r;
    logic [31:0]        period_r;

    t_quat pending_q[$];
    int    mismatches = 0;
    int    stray_results = 0;
    int    rx_hold_cnt = 0;
    int    rx_hold_req = 0;
    int    rx_hold_ack = 0;
    bit    rx_eager = 1'b0;
    bit    tx_eager = 1'b0;
    int    idle_cycles = 0;

    madgwick_imu_orientation_update_unit DUT (.*);

    always #2 i_clk = ~i_clk;

    function automatic longint unsigned isqrt(input longint unsigned x);
        longint unsigned rem, root, b;
        rem = x;
        root = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic longint m30(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic longint m16(input longint a, input longint b);
        return (a * b) >>> 16;
    endfunction

    // scale to Q.30 unit length; returns 0 for an all-zero vector
    function automatic bit to_unit(input longint v [4], output logic signed [31:0] o [4]);
        longint unsigned mag [4];
        longint unsigned mx, sum, n;
        bit neg [4];
        int msb;
        longint r;
        mx = 0;
        sum = 0;
        msb = 0;
        for (int i = 0; i < 4; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? 64'd0 - longint'(v[i]) : v[i];
            if (mag[i] > mx) mx = mag[i];
        end
        for (int i = 0; i < 4; i++) o[i] = '0;
        if (mx == 0) return 1'b0;
        while ((mx >> msb) > 1) msb++;
        for (int i = 0; i < 4; i++) begin
            if (msb > 30) mag[i] = mag[i] >> (msb - 30);
            else          mag[i] = mag[i] << (30 - msb);
            sum = sum + mag[i] * mag[i];
        end
        n = isqrt(sum);
        for (int i = 0; i < 4; i++) begin
            r = longint'((mag[i] << 30) / n);
            o[i] = neg[i] ? -r : r;
        end
        return 1'b1;
    endfunction

    function automatic longint apply_period(input longint v, input logic [31:0] p);
        longint a, b, ah, al;
        a = v * longint'({48'd0, p[31:16]});
        b = v * longint'({48'd0, p[15:0]});
        ah = a >>> 16;
        al = a - ah * 65536;
        return ah + ((al * 65536 + b) >>> 32);
    endfunction

    function automatic t_quat update_attitude(input logic signed [31:0] gx, gy, gz,
                                              input logic signed [15:0] ax, ay, az);
        longint q0, q1, q2, q3, q00, q11, q22, q33, nx, ny, nz;
        longint rate [4];
        longint grad [4];
        longint w [4];
        longint av [4];
        logic signed [31:0] an [4];
        logic signed [31:0] sn [4];
        logic signed [31:0] res [4];
        t_quat e;
        q0 = att_q[0]; q1 = att_q[1]; q2 = att_q[2]; q3 = att_q[3];
        e.fb = 1'b0;
        rate[0] = (-m16(q1, gx) - m16(q2, gy) - m16(q3, gz)) >>> 1;
        rate[1] = (m16(q0, gx) + m16(q2, gz) - m16(q3, gy)) >>> 1;
        rate[2] = (m16(q0, gy) - m16(q1, gz) + m16(q3, gx)) >>> 1;
        rate[3] = (m16(q0, gz) + m16(q1, gy) - m16(q2, gx)) >>> 1;
        if (ax != 0 || ay != 0 || az != 0) begin
            av[0] = ax; av[1] = ay; av[2] = az; av[3] = 0;
            void'(to_unit(av, an));
            nx = an[0]; ny = an[1]; nz = an[2];
            q00 = m30(q0, q0); q11 = m30(q1, q1);
            q22 = m30(q2, q2); q33 = m30(q3, q3);
            grad[0] = 4 * m30(q0, q22) + 2 * m30(q2, nx) + 4 * m30(q0, q11) - 2 * m30(q1, ny);
            grad[1] = 4 * m30(q1, q33) - 2 * m30(q3, nx) + 4 * m30(q00, q1)
                    - 2 * m30(q0, ny) - 4 * q1 + 8 * m30(q1, q11)
                    + 8 * m30(q1, q22) + 4 * m30(q1, nz);
            grad[2] = 4 * m30(q00, q2) + 2 * m30(q0, nx) + 4 * m30(q2, q33)
                    - 2 * m30(q3, ny) - 4 * q2 + 8 * m30(q2, q11)
                    + 8 * m30(q2, q22) + 4 * m30(q2, nz);
            grad[3] = 4 * m30(q11, q3) - 2 * m30(q1, nx) + 4 * m30(q22, q3) - 2 * m30(q2, ny);
            if (to_unit(grad, sn)) begin
                for (int i = 0; i < 4; i++)
                    rate[i] = rate[i] - m16(longint'({48'd0, beta_r}), sn[i]);
                e.fb = 1'b1;
            end
        end
        w[0] = q0; w[1] = q1; w[2] = q2; w[3] = q3;
        for (int i = 0; i < 4; i++) w[i] = w[i] + apply_period(rate[i], period_r);
        if (to_unit(w, res)) begin
            for (int i = 0; i < 4; i++) att_q[i] = res[i];
        end else begin
            // collapsed quaternion falls back to identity
            att_q[0] = 32'sh4000_0000;
            for (int i = 1; i < 4; i++) att_q[i] = '0;
        end
        e.qw = att_q[0]; e.qx = att_q[1]; e.qy = att_q[2]; e.qz = att_q[3];
        return e;
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_eager) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(20, 200);
    endfunction

    task automatic send_sample(input logic signed [31:0] gx, gy, gz,
                               input logic signed [15:0] ax, ay, az);
        int gap;
        bit took;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {az, ay, ax, gz, gy, gx};
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = s_axis_tready;
            @(posedge i_clk);
        end
        pending_q.push_back(update_attitude(gx, gy, gz, ax, ay, az));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == madg_pkg::CFG_BETA) beta_r = val[15:0];
        else                           period_r = val;
    endtask

    task automatic send_random();
        logic signed [31:0] g [3];
        logic signed [15:0] a [3];
        int r;
        for (int i = 0; i < 3; i++) begin
            r = $urandom_range(0, 99);
            if (r < 60)      g[i] = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            else if (r < 92) g[i] = $urandom;
            else             g[i] = '0;
        end
        r = $urandom_range(0, 99);
        for (int i = 0; i < 3; i++) a[i] = 16'($urandom);
        if (r < 8) begin
            for (int i = 0; i < 3; i++) a[i] = '0;
        end else if (r < 18) begin
            // single-axis gravity
            for (int i = 0; i < 3; i++) if (i != r % 3) a[i] = '0;
        end
        send_sample(g[0], g[1], g[2], a[0], a[1], a[2]);
    endtask

    task automatic test_directed();
        // identity state, level gravity: zero gradient
        send_sample(0, 0, 0, 0, 0, 1000);
        send_sample(0, 0, 0, 0, 0, 0);
        send_sample(0, 0, 0, 0, 0, 16'sh7FFF);
        send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                    16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 16'sh7FFF, 16'sh8000, 0);
        send_sample(65536, -65536, 32768, 100, -200, 16384);
        send_sample(0, 0, 0, 1, 0, 0);
        send_sample(0, 0, 0, 0, -1, 0);
        send_sample(-1, 1, -1, 0, 0, -1);
        send_sample(32'sh0003_2000, 0, 0, 0, 0, 0);
        send_sample(0, 32'shFFFC_0000, 0, 0, 0, 0);
        send_sample(0, 0, 32'h0006_4000, 0, 0, 0);
        drain();
        // large step with strong correction
        write_reg(madg_pkg::CFG_PERIOD, 32'hFFFF_FFFF);
        write_reg(madg_pkg::CFG_BETA, 32'h0000_FFFF);
        send_sample(32'sh0010_0000, 32'shFFF0_0000, 32'sh0008_0000, 300, -300, 16'sh8000);
        send_sample(0, 0, 0, 16'sh7FFF, 0, 0);
        send_sample(32'sh7FFF_FFFF, 0, 32'sh8000_0000, -5, 7, 0);
        send_sample(0, 0, 0, 0, 0, 0);
        drain();
        write_reg(madg_pkg::CFG_PERIOD, 32'd1);
        write_reg(madg_pkg::CFG_BETA, 32'h0000_0000);
        send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh7FFF, 0, 0);
        send_sample(32'sh8000_0000, 0, 0, 0, 16'sh8000, 0);
        drain();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(madg_pkg::CFG_BETA, 32'd6554);
                    write_reg(madg_pkg::CFG_PERIOD, 32'd42949673);
                end
                1: begin
                    write_reg(madg_pkg::CFG_BETA, 32'hFFFF);
                    write_reg(madg_pkg::CFG_PERIOD, 32'hFFFF_FFFF);
                end
                2: begin
                    write_reg(madg_pkg::CFG_BETA, 32'd0);
                    write_reg(madg_pkg::CFG_PERIOD, 32'd1);
                end
                3: begin
                    write_reg(madg_pkg::CFG_BETA, $urandom_range(0, 65535));
                    write_reg(madg_pkg::CFG_PERIOD, $urandom_range(1, 32'h0800_0000));
                end
                default: begin
                    write_reg(madg_pkg::CFG_BETA, $urandom_range(0, 65535));
                    write_reg(madg_pkg::CFG_PERIOD, $urandom | 32'd1);
                end
            endcase
            tx_eager = (ph == 2);
            rx_eager = (ph == 2);
            for (int k = 0; k < 370; k++) send_random();
            tx_eager = 1'b0;
            rx_eager = 1'b0;
            drain();
        end
    endtask

    task automatic test_backpressure();
        // receiver holds off while items keep coming
        rx_hold_req++;
        tx_eager = 1'b1;
        for (int k = 0; k < 8; k++) send_random();
        tx_eager = 1'b0;
        drain();
    endtask

    always @(posedge i_clk) begin
        if (rx_hold_req != rx_hold_ack) begin
            m_axis_tready <= 1'b0;
            rx_hold_ack <= rx_hold_req;
            rx_hold_cnt <= LONG_HOLD;
        end else if (rx_hold_cnt > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_cnt <= rx_hold_cnt - 1;
        end else if (rx_eager) begin
            m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 299) == 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_cnt <= $urandom_range(30, 400);
        end else begin
            m_axis_tready <= $urandom_range(0, 99) < 70;
        end
    end

    // check each result against the oldest prediction
    always @(negedge i_clk) begin
        t_quat e;
        t_quat got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.qw = m_axis_tdata[31:0];
            got.qx = m_axis_tdata[63:32];
            got.qy = m_axis_tdata[95:64];
            got.qz = m_axis_tdata[127:96];
            got.fb = m_axis_tuser[0];
            if (pending_q.size() == 0) begin
                stray_results++;
                if (mismatches + stray_results <= 10)
                    $display("unexpected result q=%h", m_axis_tdata);
            end else begin
                e = pending_q.pop_front();
                if (got.qw !== e.qw || got.qx !== e.qx || got.qy !== e.qy ||
                    got.qz !== e.qz || got.fb !== e.fb) begin
                    mismatches++;
                    if (mismatches + stray_results <= 10)
                        $display("mismatch exp w=%h x=%h y=%h z=%h fb=%b got w=%h x=%h y=%h z=%h fb=%b",
                                 e.qw, e.qx, e.qy, e.qz, e.fb,
                                 got.qw, got.qx, got.qy, got.qz, got.fb);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("madgwick_imu_orientation_update_unit_tb failed");
            $finish;
        end
    end

    initial begin
        att_q[0] = 32'sh4000_0000;
        for (int i = 1; i < 4; i++) att_q[i] = '0;
        beta_r = 16'd6554;
        period_r = 32'd42949673;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random_phases();
        if (mismatches == 0 && stray_results == 0 && pending_q.size() == 0)
            $display("madgwick_imu_orientation_update_unit_tb passed");
        else
            $display("madgwick_imu_orientation_update_unit_tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/madg_pkg.sv
hw/rtl/madg_norm.sv
hw/rtl/madg_dp.sv
hw/rtl/madg_ctrl.sv
hw/rtl/madgwick_imu_orientation_update_unit.sv
sim/madgwick_imu_orientation_update_unit_tb.sv
